@@ sv/alk_pkg.sv @@
package alk_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int IDX_W     = 6;
	localparam int COUNT_W   = 7;
	localparam int DEPTH_DEF = 64;

	localparam int IN_BITS   = OP_W + IDX_W + DATA_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + DATA_W + COUNT_W + 1;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
	localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ      = 3'd4;
	localparam logic [OP_W-1:0] OP_RESTART   = 3'd5;
	localparam logic [OP_W-1:0] OP_STEP      = 3'd6;

	typedef enum logic [2:0] {
		CK_NONE,
		CK_INSERT,
		CK_REMOVE,
		CK_WRITE,
		CK_READ
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t        kind;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ sv/alk_cell.sv @@
module alk_cell import alk_pkg::*; #(
	parameter int AW  = 6,
	parameter int POS = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [AW-1:0]     pos,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data_q,
	output logic [DATA_W-1:0] rd_q
);

	localparam logic [AW-1:0] MY_POS = AW'(POS);

	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			CK_INSERT: begin
				if (MY_POS == pos) begin
					data_q <= cmd.value;
				end else if (MY_POS > pos) begin
					data_q <= left;
				end
			end
			CK_REMOVE: begin
				if (MY_POS >= pos) begin
					data_q <= right;
				end
			end
			CK_WRITE: begin
				if (MY_POS == pos) begin
					data_q <= cmd.value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.kind != CK_NONE) begin
			rd_q <= (cmd.kind == CK_READ && MY_POS == pos) ? data_q : '0;
		end
	end

endmodule

@@ sv/array_list_engine.sv @@
// results pass through the cell read registers into the output register once it is free
// throughput: one request per cycle unless m_tready stalls the output; every operation,
// insert and remove included, finishes in a single shift of the cell row
// reset: arst_n clears the entry count, the iterator and all handshake state;
// entry storage is not cleared and needs no clearing pass
module array_list_engine import alk_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // op, index, value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status, read_value, count, has_more
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] iter_q;
	logic          pend_q;
	logic          stat_s1;
	logic [CW-1:0] cnt_s1;
	logic          more_s1;
	logic          out_valid_q;
	logic          stat_q;
	logic [DATA_W-1:0] rdv_q;
	logic [COUNT_W-1:0] cnt_q;
	logic          more_q;

	logic          acc;
	logic          out_load;
	logic [OP_W-1:0]   op;
	logic [IDX_W-1:0]  idx;
	logic [DATA_W-1:0] val;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] idx_x;
	logic [XW-1:0] iter_x;
	logic          full;
	logic          fail_c;
	cell_kind_t    kind_c;
	logic [XW-1:0] pos_x;
	logic [CW-1:0] count_n;
	logic [CW-1:0] iter_n;
	cell_cmd_t     cmd;
	logic [AW-1:0] cmd_pos;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_rd [DEPTH];
	logic [DEPTH-1:0]  rd_col [DATA_W];
	logic [DATA_W-1:0] rd_word;

	assign op  = s_tdata[OP_W-1:0];
	assign idx = s_tdata[OP_W +: IDX_W];
	assign val = s_tdata[OP_W + IDX_W +: DATA_W];

	assign out_load = pend_q && (!out_valid_q || m_tready);
	assign s_tready = !pend_q || out_load;
	assign acc      = s_tvalid && s_tready;

	assign cnt_x  = XW'(count_q);
	assign idx_x  = XW'(idx);
	assign iter_x = XW'(iter_q);
	assign full   = count_q >= CW'(DEPTH);

	always_comb begin
		fail_c  = 1'b0;
		kind_c  = CK_NONE;
		pos_x   = idx_x;
		count_n = count_q;
		iter_n  = iter_q;
		unique case (op)
			OP_APPEND: begin
				pos_x = cnt_x;
				if (full) begin
					fail_c = 1'b1;
				end else begin
					kind_c  = CK_INSERT;
					count_n = CW'(count_q + 1'b1);
				end
			end
			OP_INSERT: begin
				if (full || idx_x > cnt_x) begin
					fail_c = 1'b1;
				end else begin
					kind_c  = CK_INSERT;
					count_n = CW'(count_q + 1'b1);
				end
			end
			OP_REMOVE: begin
				if (idx_x >= cnt_x) begin
					fail_c = 1'b1;
				end else begin
					kind_c  = CK_REMOVE;
					count_n = CW'(count_q - 1'b1);
				end
			end
			OP_OVERWRITE: begin
				if (idx_x >= cnt_x) begin
					fail_c = 1'b1;
				end else begin
					kind_c = CK_WRITE;
				end
			end
			OP_READ: begin
				if (idx_x >= cnt_x) begin
					fail_c = 1'b1;
				end else begin
					kind_c = CK_READ;
				end
			end
			OP_RESTART: begin
				iter_n = '0;
			end
			OP_STEP: begin
				pos_x = iter_x;
				if (iter_q >= count_q) begin
					fail_c = 1'b1;
				end else begin
					kind_c = CK_READ;
					iter_n = CW'(iter_q + 1'b1);
				end
			end
			default: begin
				fail_c = 1'b1;
			end
		endcase
	end

	// failed and empty requests still clear the cell read registers
	assign cmd.kind  = acc ? ((kind_c == CK_NONE) ? CK_WRITE : kind_c) : CK_NONE;
	assign cmd.value = val;
	assign cmd_pos   = (acc && kind_c == CK_NONE) ? AW'(DEPTH - 1) : AW'(pos_x);

	// a no-op request rewrites the last cell with its own value
	logic [DATA_W-1:0] wr_hold;
	assign wr_hold = cell_data[DEPTH-1];

	cell_cmd_t cell_cmd;
	always_comb begin
		cell_cmd = cmd;
		if (acc && kind_c == CK_NONE) begin
			cell_cmd.value = wr_hold;
		end
	end

	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;
			if (k == 0) begin : g_first
				assign left_d = cell_data[k];
			end else begin : g_left
				assign left_d = cell_data[k-1];
			end
			if (k == DEPTH - 1) begin : g_last
				assign right_d = cell_data[k];
			end else begin : g_right
				assign right_d = cell_data[k+1];
			end
			alk_cell #(
				.AW  (AW),
				.POS (k)
			) u_cell (
				.clk    (clk),
				.cmd    (cell_cmd),
				.pos    (cmd_pos),
				.left   (left_d),
				.right  (right_d),
				.data_q (cell_data[k]),
				.rd_q   (cell_rd[k])
			);
			for (genvar b = 0; b < DATA_W; b++) begin : g_col
				assign rd_col[b][k] = cell_rd[k][b];
			end
		end
		for (genvar b = 0; b < DATA_W; b++) begin : g_or
			assign rd_word[b] = |rd_col[b];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iter_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_n;
				iter_q  <= iter_n;
				pend_q  <= 1'b1;
			end else if (out_load) begin
				pend_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stat_s1 <= fail_c;
			cnt_s1  <= count_n;
			more_s1 <= iter_n < count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			stat_q <= stat_s1;
			rdv_q  <= rd_word;
			cnt_q  <= COUNT_W'(cnt_s1);
			more_q <= more_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, more_q, cnt_q, rdv_q, stat_q};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(count_q) && $stable(iter_q))
		else $error("list state moved without a request");

	a_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pend_q)
		else $error("accepted request not held for output");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not offered");
`endif

endmodule
